[sv/avsfp_pkg.sv]
`default_nettype none

package avsfp_pkg;

   // defaults for top-level parameters
   localparam int CLOCK_BITS_DEF   = 50;
   localparam int COUNTER_WRAP_DEF = 500;

   // field widths
   localparam int TIME_W   = 50;
   localparam int REP_W    = 4;
   localparam int TB_W     = 30;
   localparam int PERIOD_W = 10;
   localparam int DELAY_W  = 19;
   localparam int CSR_IDX_W = 2;

   // packed beat widths (tdata padded to whole bytes)
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_BASE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_RATE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_PRESENT = 2'd3;

   // register reset values
   localparam logic [TB_W-1:0]     TIME_BASE_RST    = 30'd11111;
   localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 10'd40;

   // largest delay any update can produce: 2 * 1023 ms in Q8
   localparam logic [DELAY_W-1:0] DELAY_MAX_Q8 = 19'd523776;

   // audio/video skew classification for one frame
   typedef struct packed {
      logic lag;      // audio ahead of video
      logic lead;     // video ahead of audio
      logic zero;     // no skew (or no audio)
      logic gt_3ms;
      logic gt_1s;
      logic gt_10s;
      logic ge_half;  // skew of half a second or more
   } sync_type;

endpackage

`default_nettype wire

[sv/avsfp_vclk.sv]
`default_nettype none

module avsfp_vclk #(
   parameter int CLOCK_BITS = avsfp_pkg::CLOCK_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic [avsfp_pkg::TIME_W-1:0]        pts_ns,
   input  wire logic [avsfp_pkg::REP_W-1:0]         repeat_count,
   input  wire logic [avsfp_pkg::TIME_W-1:0]        audio_ns,
   input  wire logic [avsfp_pkg::TB_W-1:0]          time_base_ns,
   input  wire logic                                audio_present,
   output logic      [avsfp_pkg::TIME_W-1:0]        display_ns,
   output avsfp_pkg::sync_type                      sync
);

   // compare width covers both the clock and the 50-bit audio time
   localparam int W  = (CLOCK_BITS > avsfp_pkg::TIME_W) ? CLOCK_BITS : avsfp_pkg::TIME_W;
   // advance is at most 35 bits
   localparam int ADV_W = avsfp_pkg::TB_W + avsfp_pkg::REP_W + 1;
   localparam int AW = (CLOCK_BITS > ADV_W) ? CLOCK_BITS : ADV_W;

   localparam logic [W-1:0] NS_3MS    = W'(64'd3000000);
   localparam logic [W-1:0] NS_HALF_S = W'(64'd500000000);
   localparam logic [W-1:0] NS_1S     = W'(64'd1000000000);
   localparam logic [W-1:0] NS_10S    = W'(64'd10000000000);

   logic [CLOCK_BITS-1:0] vclk_ff, vclk_in;
   logic [CLOCK_BITS-1:0] disp;
   logic [W-1:0]          pts_w, disp_w, audio_w, mag;
   logic [ADV_W-2:0]      rep_tb;
   logic [ADV_W-1:0]      adv;
   logic                  a_ge;

   always_comb begin
      pts_w   = W'(pts_ns);
      disp    = (pts_ns != '0) ? pts_w[CLOCK_BITS-1:0] : vclk_ff;
      rep_tb  = (ADV_W-1)'(repeat_count) * (ADV_W-1)'(time_base_ns);
      adv     = ADV_W'(time_base_ns) + ADV_W'(rep_tb >> 1);
      vclk_in = step ? CLOCK_BITS'(AW'(disp) + AW'(adv)) : vclk_ff;

      disp_w     = W'(disp);
      audio_w    = W'(audio_ns);
      display_ns = avsfp_pkg::TIME_W'(disp_w);

      a_ge = audio_w >= disp_w;
      mag  = a_ge ? (audio_w - disp_w) : (disp_w - audio_w);

      sync.lag     = audio_present && a_ge && (mag != '0);
      sync.lead    = audio_present && !a_ge;
      sync.zero    = !audio_present || (mag == '0);
      sync.gt_3ms  = audio_present && (mag > NS_3MS);
      sync.gt_1s   = audio_present && (mag > NS_1S);
      sync.gt_10s  = audio_present && (mag > NS_10S);
      sync.ge_half = audio_present && (mag >= NS_HALF_S);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vclk_ff <= '0;
      end else begin
         vclk_ff <= vclk_in;
      end
   end

endmodule

`default_nettype wire

[sv/avsfp_delay.sv]
`default_nettype none

module avsfp_delay #(
   parameter int COUNTER_WRAP = avsfp_pkg::COUNTER_WRAP_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire avsfp_pkg::sync_type                 sync,
   input  wire logic [avsfp_pkg::PERIOD_W-1:0]      frame_period_ms,
   input  wire logic                                high_frame_rate,
   output logic      [avsfp_pkg::DELAY_W-1:0]       delay_q8,
   output logic                                     drop_frame
);

   localparam int DW = avsfp_pkg::DELAY_W;
   localparam int CW = $clog2(COUNTER_WRAP + 1);

   // floor(x/3) by reciprocal: exact for x below 2^20
   localparam logic [20:0] DIV3_M20 = 21'd699051;
   // floor(r/3) for 10-bit r: exact for r below 2^11
   localparam logic [9:0]  DIV3_M10 = 10'd683;

   function automatic logic [19:0] div3_20(input logic [19:0] x);
      logic [40:0] p;
      p = 41'(x) * 41'(DIV3_M20);
      return 20'(p >> 21);
   endfunction

   function automatic logic [9:0] div3_10(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'(DIV3_M10);
      return 10'(p >> 11);
   endfunction

   logic [DW-1:0] delay_ff, delay_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    mod3_ff, mod3_in;   // cnt_ff mod 3

   logic [DW-1:0] half_q8, lo_q8, hi_q8, base_q8, clamped;
   logic [9:0]    r_third;
   logic [19:0]   down;
   logic [20:0]   up, scaled;
   logic          wrap_hit;

   always_comb begin
      r_third = div3_10(frame_period_ms);
      half_q8 = DW'({frame_period_ms[9:1], 8'h00});
      lo_q8   = DW'({r_third, 9'h000});
      hi_q8   = {frame_period_ms, 9'h000};
      base_q8 = DW'({frame_period_ms, 8'h00});

      down   = div3_20({delay_ff, 1'b0});
      up     = (21'(delay_ff) + 21'({delay_ff, 1'b0})) >> 1;
      scaled = sync.lag ? 21'(down) : up;

      if (scaled < 21'(half_q8)) begin
         clamped = lo_q8;
      end else if (scaled > 21'(hi_q8)) begin
         clamped = hi_q8;
      end else begin
         clamped = scaled[DW-1:0];
      end

      if (sync.gt_3ms && (sync.lag || sync.lead)) begin
         delay_q8 = clamped;
      end else if (sync.zero) begin
         delay_q8 = base_q8;
      end else begin
         delay_q8 = delay_ff;
      end
      // large gaps override the tracking
      if (sync.lag && sync.gt_1s) begin
         delay_q8 = '0;
      end
      if (sync.lead && sync.gt_1s) begin
         delay_q8 = hi_q8;
      end
      if (sync.gt_10s) begin
         delay_q8 = base_q8;
      end

      wrap_hit = cnt_ff == CW'(COUNTER_WRAP);
      if (wrap_hit) begin
         cnt_in  = '0;
         mod3_in = 2'd0;
      end else begin
         cnt_in  = cnt_ff + CW'(1);
         mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
      end

      drop_frame = sync.lag && sync.ge_half && (!high_frame_rate || (mod3_in == 2'd0));
      delay_in   = delay_q8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         cnt_ff   <= '0;
         mod3_ff  <= '0;
      end else if (step) begin
         delay_ff <= delay_in;
         cnt_ff   <= cnt_in;
         mod3_ff  <= mod3_in;
      end
   end

endmodule

`default_nettype wire

[sv/av_sync_frame_pacer.sv]
`default_nettype none

// Audio/video frame pacer. Each req beat carries one decoded video frame (timestamp,
// repeat count, audio clock); each rsp beat returns that frame's display time, the
// delay to wait before showing it (ms, 8 fraction bits) and, in tuser, a drop flag.
// A zero timestamp means "none": the frame takes the running video clock. The block
// takes one frame per clock cycle while rsp is not stalled and answers exactly once per
// frame, in order. A frame enters the input register when its req beat is taken and
// moves into the result register once that register is free; its result is then on rsp.
// The per-frame update of the video clock, pace delay and frame counter is combinational
// between the two registers. Backpressure on rsp holds both stages; req_tready stays
// high while the input stage can move on. CSR writes are taken at any cycle but must
// only be issued with no frame in flight.
module av_sync_frame_pacer #(
   parameter int CLOCK_BITS   = avsfp_pkg::CLOCK_BITS_DEF,
   parameter int COUNTER_WRAP = avsfp_pkg::COUNTER_WRAP_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req_tdata: frame_pts_ns[49:0], repeat_count[53:50], audio_clock_ns[103:54]
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [avsfp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: display_time_ns[49:0], delay_ms_q8[68:50], zero pad [71:69]
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [avsfp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: drop_frame[0]
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [avsfp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [avsfp_pkg::TB_W-1:0]            csr_wdata
);

   localparam int TW = avsfp_pkg::TIME_W;
   localparam int DW = avsfp_pkg::DELAY_W;

   // config registers
   logic [avsfp_pkg::TB_W-1:0]     time_base_ff;
   logic [avsfp_pkg::PERIOD_W-1:0] period_ff;
   logic                           high_rate_ff;
   logic                           audio_present_ff;

   // input stage
   logic                           s1_valid_ff, s1_valid_in;
   logic [TW-1:0]                  s1_pts_ff, s1_audio_ff;
   logic [avsfp_pkg::REP_W-1:0]    s1_rep_ff;

   // result stage
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]                  rsp_disp_ff;
   logic [DW-1:0]                  rsp_delay_ff;
   logic                           rsp_drop_ff;

   logic                           advance, req_fire, s1_fire;
   logic [TW-1:0]                  disp_ns;
   logic [DW-1:0]                  delay_q8;
   logic                           drop_frame;
   avsfp_pkg::sync_type            sync;

   // the result register frees up when empty or being drained
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign s1_fire     = s1_valid_ff && advance;
   assign req_tready  = !s1_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_delay_ff, rsp_disp_ff};
   assign rsp_tuser  = rsp_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff     <= avsfp_pkg::TIME_BASE_RST;
         period_ff        <= avsfp_pkg::FRAME_PERIOD_RST;
         high_rate_ff     <= 1'b0;
         audio_present_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            avsfp_pkg::CSR_TIME_BASE:     time_base_ff     <= csr_wdata;
            avsfp_pkg::CSR_FRAME_PERIOD:  period_ff        <= csr_wdata[avsfp_pkg::PERIOD_W-1:0];
            avsfp_pkg::CSR_HIGH_RATE:     high_rate_ff     <= csr_wdata[0];
            avsfp_pkg::CSR_AUDIO_PRESENT: audio_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pts_ff   <= req_tdata[49:0];
         s1_rep_ff   <= req_tdata[53:50];
         s1_audio_ff <= req_tdata[103:54];
      end
      if (s1_fire) begin
         rsp_disp_ff  <= disp_ns;
         rsp_delay_ff <= delay_q8;
         rsp_drop_ff  <= drop_frame;
      end
   end

   avsfp_vclk #(
      .CLOCK_BITS (CLOCK_BITS)
   ) u_vclk (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_fire),
      .pts_ns        (s1_pts_ff),
      .repeat_count  (s1_rep_ff),
      .audio_ns      (s1_audio_ff),
      .time_base_ns  (time_base_ff),
      .audio_present (audio_present_ff),
      .display_ns    (disp_ns),
      .sync          (sync)
   );

   avsfp_delay #(
      .COUNTER_WRAP (COUNTER_WRAP)
   ) u_delay (
      .clock           (clock),
      .reset           (reset),
      .step            (s1_fire),
      .sync            (sync),
      .frame_period_ms (period_ff),
      .high_frame_rate (high_rate_ff),
      .delay_q8        (delay_q8),
      .drop_frame      (drop_frame)
   );

   // a frame leaving the input stage always lands in the result register
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("frame lost between input and result stage");

   // full pipe with stalled output must not take another beat
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("req accepted while pipe is full");

   // delay never exceeds twice the largest frame period
   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_delay_ff <= avsfp_pkg::DELAY_MAX_Q8))
      else $error("pace delay out of range");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

// Frame pacer bench: a driver streams frames on req, a monitor takes results on rsp and
// checks each one against an in-bench pacing model updated at every accepted req beat.
module tb_top;
   import avsfp_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int MAX_PRINTS  = 50;

   // skew thresholds, ns
   localparam longint unsigned NS_3MS    = 64'd3_000_000;
   localparam longint unsigned NS_HALF_S = 64'd500_000_000;
   localparam longint unsigned NS_1S     = 64'd1_000_000_000;
   localparam longint unsigned NS_10S    = 64'd10_000_000_000;

   typedef struct packed {
      logic [TIME_W-1:0] pts;
      logic [REP_W-1:0]  rep;
      logic [TIME_W-1:0] audio;
   } frame_t;

   typedef struct packed {
      logic [TIME_W-1:0]  disp;
      logic               drop;
      logic [DELAY_W-1:0] delay;
   } paced_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_TIME_BASE;
   logic [TB_W-1:0]       csr_wdata  = '0;

   av_sync_frame_pacer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // pacing model: register copies and running state
   // ------------------------------------------------------------------
   logic [TB_W-1:0]     cfg_time_base = TIME_BASE_RST;
   logic [PERIOD_W-1:0] cfg_period    = FRAME_PERIOD_RST;
   logic                cfg_high_rate = 1'b0;
   logic                cfg_audio     = 1'b1;

   logic [TIME_W-1:0]   video_clk = '0;
   logic [19:0]         pace_q8   = '0;
   int                  frame_cnt = 0;

   frame_t frame_backlog[$];    // frames waiting for the driver
   paced_t expected_frames[$];  // predicted results, oldest first

   int src_idle_pct  = 32;
   int sink_idle_pct = 70;
   int mismatches    = 0;
   int frames_out    = 0;
   int beats_sent    = 0;
   int cycle_count   = 0;
   bit awaiting_drain = 1'b0;

   // stimulus-side copy of the video clock, so audio can be placed at a chosen skew
   logic [TIME_W-1:0] gen_vclock = '0;

   // One frame through the pacer: display time, delay update, counter, drop decision.
   function automatic paced_t pace_frame(frame_t f);
      logic [63:0] mag;
      logic [63:0] step;
      logic        lag;
      logic        lead;
      logic [31:0] r;
      logic [31:0] d;
      logic [31:0] half;
      logic [31:0] lo;
      logic [31:0] hi;
      paced_t      res;
      if (f.pts != '0) video_clk = f.pts;
      res.disp  = video_clk;
      // repeats add half a time base each, fraction dropped
      step      = 64'(cfg_time_base) + ((64'(f.rep) * 64'(cfg_time_base)) >> 1);
      video_clk = video_clk + step[TIME_W-1:0];

      mag  = '0;
      lag  = 1'b0;
      lead = 1'b0;
      if (cfg_audio) begin
         if (f.audio >= res.disp) begin
            mag = 64'(f.audio) - 64'(res.disp);
            lag = (mag != 0);
         end else begin
            mag  = 64'(res.disp) - 64'(f.audio);
            lead = 1'b1;
         end
      end

      r    = 32'(cfg_period);
      d    = 32'(pace_q8);
      half = (r / 2) << 8;
      lo   = ((r / 3) * 2) << 8;
      hi   = (r * 2) << 8;
      if ((lag || lead) && mag > NS_3MS) begin
         d = lag ? (d * 2) / 3 : (d * 3) >> 1;
         if (d < half)
            d = lo;
         else if (d > hi)
            d = hi;
      end else if (mag == 0) begin
         d = r << 8;
      end
      // large gaps override the gradual update
      if (lag && mag > NS_1S) d = 0;
      if (lead && mag > NS_1S) d = hi;
      if (mag > NS_10S) d = r << 8;
      pace_q8 = d[19:0];

      frame_cnt++;
      if (frame_cnt > COUNTER_WRAP_DEF) frame_cnt = 0;

      res.drop = 1'b0;
      if (lag && mag >= NS_HALF_S)
         res.drop = cfg_high_rate ? (frame_cnt % 3 == 0) : 1'b1;
      res.delay = pace_q8[DELAY_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] rand_ns();
      return TIME_W'({$urandom, $urandom});
   endfunction

   // Builds a frame whose audio sits at the given skew from its display time.
   function automatic frame_t mk_frame(logic [TIME_W-1:0] pts, logic [REP_W-1:0] rep,
                                       longint skew);
      frame_t      f;
      logic [63:0] step;
      f.pts = pts;
      f.rep = rep;
      if (pts != '0) gen_vclock = pts;
      f.audio    = TIME_W'(longint'(gen_vclock) + skew);
      step       = 64'(cfg_time_base) + ((64'(rep) * 64'(cfg_time_base)) >> 1);
      gen_vclock = gen_vclock + step[TIME_W-1:0];
      return f;
   endfunction

   task automatic flag_mismatch(string what);
      if (mismatches < MAX_PRINTS)
         $display("MISMATCH at result %0d: %s", frames_out, what);
      mismatches++;
   endtask

   // registers only change with nothing in flight
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TB_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TIME_BASE:     cfg_time_base = val;
         CSR_FRAME_PERIOD:  cfg_period    = val[PERIOD_W-1:0];
         CSR_HIGH_RATE:     cfg_high_rate = val[0];
         CSR_AUDIO_PRESENT: cfg_audio     = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (frame_backlog.size() != 0 || req_tvalid || expected_frames.size() != 0)
         @(posedge clock);
   endtask

   // One random phase: drain, reprogram, then queue well-formed frames with a chosen
   // skew class plus some raw noise.
   task automatic run_phase(logic [TB_W-1:0] tbase, logic [PERIOD_W-1:0] period,
                            logic hfr, logic audio_on, int src_pct, int sink_pct,
                            int count);
      frame_t            f;
      logic [TIME_W-1:0] pts;
      longint            skew;
      int                pick;
      wait_drained();
      write_csr(CSR_TIME_BASE, tbase);
      write_csr(CSR_FRAME_PERIOD, TB_W'(period));
      write_csr(CSR_HIGH_RATE, TB_W'(hfr));
      write_csr(CSR_AUDIO_PRESENT, TB_W'(audio_on));
      csr_we        <= 1'b0;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      gen_vclock    = video_clk;
      repeat (count) begin
         if ($urandom_range(99) < 8) begin
            // noise: arbitrary timestamp and audio clock
            f = mk_frame($urandom_range(1) ? rand_ns() : '0, REP_W'($urandom_range(15)), 0);
            f.audio = rand_ns();
         end else begin
            pick = $urandom_range(9);
            if (pick < 3)
               pts = '0;
            else if (pick == 3)
               pts = rand_ns();
            else
               pts = gen_vclock + TIME_W'($urandom_range(2_000_000));
            case ($urandom_range(6))
               0: skew = 0;
               1: skew = longint'($urandom_range(3_000_000));
               2: skew = 64'sd3_000_001 + longint'($urandom_range(496_999_998));
               3: skew = 64'sd1_000_000_001 + longint'($urandom) * 2;
               4: skew = 64'sd10_000_000_001 + longint'($urandom) * 1000;
               default: skew = 64'sd500_000_000 + longint'($urandom_range(500_000_000));
            endcase
            // late-frame classes stay late so drops keep coming
            if ($urandom_range(1) && skew < 64'sd500_000_000) skew = -skew;
            f = mk_frame(pts, REP_W'($urandom_range(15)), skew);
         end
         frame_backlog.push_back(f);
      end
   endtask

   // ------------------------------------------------------------------
   // clock and run limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // req driver: predicts each frame as its beat is taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      frame_t beat;
      frame_t next_frame;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            beat.pts   = req_tdata[49:0];
            beat.rep   = req_tdata[53:50];
            beat.audio = req_tdata[103:54];
            expected_frames.push_back(pace_frame(beat));
         end
         // hold-off: released once every outstanding result is back
         if (awaiting_drain && !req_tvalid && expected_frames.size() == 0)
            awaiting_drain = 1'b0;
         if (!req_tvalid || req_tready) begin
            if (frame_backlog.size() != 0 && !awaiting_drain &&
                $urandom_range(99) >= src_idle_pct) begin
               next_frame = frame_backlog.pop_front();
               req_tdata  <= {next_frame.audio, next_frame.rep, next_frame.pts};
               req_tvalid <= 1'b1;
               beats_sent++;
               if (beats_sent % 128 == 0) awaiting_drain = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp monitor: random backpressure, in-order field compare
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      paced_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               flag_mismatch("result beat with no frame outstanding");
            end else begin
               want = expected_frames.pop_front();
               if (rsp_tdata[49:0] !== want.disp)
                  flag_mismatch($sformatf("display_time_ns got %0d want %0d",
                                          rsp_tdata[49:0], want.disp));
               if (rsp_tdata[68:50] !== want.delay)
                  flag_mismatch($sformatf("delay_ms_q8 got %0d want %0d",
                                          rsp_tdata[68:50], want.delay));
               if (rsp_tuser !== want.drop)
                  flag_mismatch($sformatf("drop_frame got %0b want %0b",
                                          rsp_tuser, want.drop));
            end
            frames_out++;
         end
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : sequence_main
      frame_t f;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed frames on the reset register values (time base 11111 ns, 40 ms period).
      // aligned frame sets the delay to the period; untimed frames ride the video clock
      frame_backlog.push_back(mk_frame(50'd5_000_000_000, 4'd0, 0));
      frame_backlog.push_back(mk_frame('0, 4'd15, 64'sd2_000_000));
      frame_backlog.push_back(mk_frame('0, 4'd1, -64'sd2_000_000));   // odd half step
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd3_000_000));    // exactly 3 ms: hold
      // lagging just past 3 ms: shrink down into the low clamp
      repeat (4) frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd3_000_001));
      // leading just past 3 ms: grow up into the high clamp
      repeat (3) frame_backlog.push_back(mk_frame('0, 4'd0, -64'sd3_000_001));
      // drop threshold
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd499_999_999));
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd500_000_000));
      // one-second override, both sides
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd1_000_000_000));
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd1_000_000_001));
      frame_backlog.push_back(mk_frame('0, 4'd0, -64'sd1_000_000_000));
      frame_backlog.push_back(mk_frame('0, 4'd0, -64'sd1_000_000_001));
      // ten-second override
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd10_000_000_000));
      frame_backlog.push_back(mk_frame('0, 4'd0, 64'sd10_000_000_001));
      frame_backlog.push_back(mk_frame('0, 4'd0, -64'sd10_000_000_001));
      // top timestamp with audio at zero, then the wrapped clock on an untimed frame
      f = mk_frame({TIME_W{1'b1}}, 4'd15, 0);
      f.audio = '0;
      frame_backlog.push_back(f);
      frame_backlog.push_back(mk_frame('0, 4'd0, 0));
      // smallest timestamp against the top audio clock
      f = mk_frame(50'd1, 4'd0, 0);
      f.audio = {TIME_W{1'b1}};
      frame_backlog.push_back(f);

      // random phases: receiver-heavy idling, then sender-heavy, then none
      run_phase(30'd33_366_667, 10'd33, 1'b0, 1'b1, 32, 70, 165);
      run_phase(30'd16_666_667, 10'd16, 1'b1, 1'b1, 32, 70, 165);
      run_phase(30'd0, 10'd0, 1'b0, 1'b1, 70, 32, 165);            // frozen clock, zero period
      run_phase(30'h3FFF_FFFF, 10'd1023, 1'b1, 1'b1, 70, 32, 165);  // largest settings
      run_phase(30'd40_000_000, 10'd40, 1'b0, 1'b0, 0, 0, 165);     // no audio clock
      run_phase(30'd1, 10'd1, 1'b1, 1'b1, 0, 0, 165);

      wait_drained();
      // two-stage pipe: waiting on here catches any stray result
      repeat (8) @(posedge clock);
      if (expected_frames.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
